FILE: hw/rtl/sdph_pkg.sv
// Types and constants shared by the straight-drive heading-hold controller.
// Used by sdph_front, sdph_pid and straight_drive_pid_heading_hold.
// No dependencies.
package sdph_pkg;

  // request kinds
  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KP_GAIN        = 3'd0,
    CFG_KI_GAIN        = 3'd1,
    CFG_KD_GAIN        = 3'd2,
    CFG_HEADING_GAIN   = 3'd3,
    CFG_TICKS_PER_INCH = 3'd4,
    CFG_TARGET_HEADING = 3'd5
  } cfg_idx_e;

  // register reset values
  localparam logic [15:0] KP_RESET  = 16'd256;
  localparam logic [15:0] TPI_RESET = 16'd9933;

  // short move threshold: 12 inches in sixteenths
  localparam logic signed [15:0] SHORT_DIST = 16'sd192;

  // heading wrap, centidegrees
  localparam logic signed [17:0] HDG_OFFSET = 18'sd54000;
  localparam logic signed [17:0] HDG_FULL   = 18'sd36000;
  localparam logic signed [17:0] HDG_DOUBLE = 18'sd72000;
  localparam logic signed [17:0] HDG_HALF   = 18'sd18000;

  // integral window, in encoder ticks
  localparam logic [28:0] ERR_WIN_LO = 29'd8;
  localparam logic [28:0] ERR_WIN_HI = 29'd2400;

  // integral saturation
  localparam logic signed [40:0] SUM_MAX = 41'sd549755813887;
  localparam logic signed [40:0] SUM_MIN = -41'sd549755813887;

  // side power limit, 16 fractional bits
  localparam logic signed [33:0] PWR_LIM   = 34'sd8323072;
  localparam logic signed [33:0] PWR_LIM_N = -34'sd8323072;
  localparam logic signed [33:0] PWR_ROUND = 34'sd65535;

  // gains seen by the pid datapath
  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
  } sdph_gains_t;

  // request after the front-end stage
  typedef struct packed {
    cmd_e                cmd;
    logic signed [23:0]  target;
    logic [6:0]          speed;
    logic                short_move;
    logic signed [27:0]  mean;
    logic signed [31:0]  hcorr;
  } sdph_req_t;

  // move state
  typedef struct packed {
    logic signed [23:0]  target;
    logic signed [28:0]  pos_err;
    logic signed [28:0]  last_err;
    logic signed [39:0]  err_sum;
    logic [6:0]          speed;
    logic                short_move;
    logic                moving;
  } sdph_state_t;

  // result of one request
  typedef struct packed {
    logic signed [7:0] left_power;
    logic signed [7:0] right_power;
    logic              done;
  } sdph_res_t;

  // clamp one side to +-127 and truncate toward zero
  function automatic logic signed [7:0] side_power(input logic signed [33:0] x);
    logic signed [33:0] c;
    logic signed [33:0] adj;
    if (x > PWR_LIM) begin
      c = PWR_LIM;
    end else if (x < PWR_LIM_N) begin
      c = PWR_LIM_N;
    end else begin
      c = x;
    end
    adj = c[33] ? (c + PWR_ROUND) : c;
    return adj[23:16];
  endfunction

endpackage

FILE: hw/rtl/sdph_front.sv
// Front-end of the heading-hold controller: move target, mean position,
// wrapped heading error and heading correction for one incoming request.
// Depends on sdph_pkg.
module sdph_front (
  input  sdph_pkg::cmd_e        command_i,
  input  logic signed [15:0]    distance_i,
  input  logic [6:0]            max_speed_i,
  input  logic signed [27:0]    left_ticks_i,
  input  logic signed [27:0]    right_ticks_i,
  input  logic [15:0]           heading_i,
  input  logic [15:0]           ticks_per_inch_i,
  input  logic [15:0]           target_heading_i,
  input  logic [15:0]           heading_gain_i,
  output sdph_pkg::sdph_req_t   req_o
);

  logic signed [32:0] dist_prod;
  logic signed [32:0] dist_adj;
  logic signed [28:0] tick_sum;
  logic signed [17:0] hd0;
  logic signed [17:0] hd1;
  logic signed [17:0] hd2;
  logic signed [17:0] hd3;
  logic signed [17:0] herr_w;
  logic signed [15:0] herr;
  logic signed [32:0] hprod;

  // target = distance * ticks_per_inch / 256, toward zero
  assign dist_prod = distance_i * $signed({1'b0, ticks_per_inch_i});
  assign dist_adj  = dist_prod[32] ? (dist_prod + 33'sd255) : dist_prod;

  // floor of the mean encoder position
  assign tick_sum = 29'(left_ticks_i) + 29'(right_ticks_i);

  // wrapped heading error, non-negative modulo
  always_comb begin
    hd0 = $signed({2'b00, target_heading_i}) - $signed({2'b00, heading_i})
          + sdph_pkg::HDG_OFFSET;
    hd1 = hd0[17] ? (hd0 + sdph_pkg::HDG_FULL) : hd0;
    hd2 = (hd1 >= sdph_pkg::HDG_DOUBLE) ? (hd1 - sdph_pkg::HDG_DOUBLE) : hd1;
    hd3 = (hd2 >= sdph_pkg::HDG_FULL) ? (hd2 - sdph_pkg::HDG_FULL) : hd2;
    herr_w = hd3 - sdph_pkg::HDG_HALF;
  end

  assign herr  = herr_w[15:0];
  assign hprod = herr * $signed({1'b0, heading_gain_i});

  // pack the request
  always_comb begin
    req_o.cmd        = command_i;
    req_o.target     = dist_adj[31:8];
    req_o.speed      = max_speed_i;
    req_o.short_move = (distance_i < sdph_pkg::SHORT_DIST);
    req_o.mean       = tick_sum[28:1];
    req_o.hcorr      = hprod[31:0];
  end

endmodule

FILE: hw/rtl/sdph_pid.sv
// PID datapath of the heading-hold controller: side powers, done flag and
// next move state for one request, from the current move state.
// Depends on sdph_pkg.
module sdph_pid (
  input  sdph_pkg::sdph_state_t state_i,
  input  sdph_pkg::sdph_gains_t gains_i,
  input  sdph_pkg::sdph_req_t   req_i,
  output sdph_pkg::sdph_state_t state_o,
  output sdph_pkg::sdph_res_t   res_o
);

  logic [16:0]        kp_eff;
  logic signed [28:0] pos_err;
  logic signed [28:0] last_err;
  logic signed [39:0] err_sum;
  logic signed [46:0] p_term;
  logic signed [29:0] d_diff;
  logic signed [46:0] d_term;
  logic signed [56:0] i_term;
  logic signed [58:0] pid_raw;
  logic signed [58:0] pid_lim;
  logic signed [58:0] pid_lim_n;
  logic signed [15:0] pid_c;
  logic signed [33:0] pid_q16;
  logic signed [33:0] hc_ext;
  logic signed [28:0] err_new;
  logic [28:0]        err_abs;
  logic signed [40:0] sum_raw;
  logic signed [39:0] sum_new;
  logic signed [28:0] mean_ext;
  logic signed [28:0] tgt_ext;
  logic [28:0]        mean_abs;
  logic [28:0]        tgt_abs;

  assign pos_err  = state_i.pos_err;
  assign last_err = state_i.last_err;
  assign err_sum  = state_i.err_sum;

  // pid terms from the error left by the previous sample
  assign kp_eff = state_i.short_move ? {gains_i.kp, 1'b0} : {1'b0, gains_i.kp};
  assign p_term = pos_err * $signed({1'b0, kp_eff});
  assign i_term = err_sum * $signed({1'b0, gains_i.ki});
  assign d_diff = 30'(pos_err) - 30'(last_err);
  assign d_term = d_diff * $signed({1'b0, gains_i.kd});
  assign pid_raw = 59'(p_term) + 59'(i_term) + 59'(d_term);

  // clamp to the move speed limit
  assign pid_lim   = $signed({44'd0, state_i.speed, 8'd0});
  assign pid_lim_n = -pid_lim;

  always_comb begin
    if (pid_raw > pid_lim) begin
      pid_c = pid_lim[15:0];
    end else if (pid_raw < pid_lim_n) begin
      pid_c = pid_lim_n[15:0];
    end else begin
      pid_c = pid_raw[15:0];
    end
  end

  // shift to 16 fractional bits for the heading correction
  assign pid_q16 = $signed({{10{pid_c[15]}}, pid_c, 8'd0});
  assign hc_ext  = 34'(req_i.hcorr);

  // new error from the mean position, integral window and saturation
  assign mean_ext = 29'(req_i.mean);
  assign tgt_ext  = 29'(state_i.target);
  assign err_new  = tgt_ext - mean_ext;
  assign err_abs  = err_new[28] ? 29'(-err_new) : 29'(err_new);
  assign sum_raw  = 41'(err_sum) + 41'(err_new);

  always_comb begin
    if ((err_abs < sdph_pkg::ERR_WIN_LO) || (err_abs > sdph_pkg::ERR_WIN_HI)) begin
      sum_new = '0;
    end else if (sum_raw > sdph_pkg::SUM_MAX) begin
      sum_new = sdph_pkg::SUM_MAX[39:0];
    end else if (sum_raw < sdph_pkg::SUM_MIN) begin
      sum_new = sdph_pkg::SUM_MIN[39:0];
    end else begin
      sum_new = sum_raw[39:0];
    end
  end

  // done test on magnitudes
  assign mean_abs = mean_ext[28] ? 29'(-mean_ext) : 29'(mean_ext);
  assign tgt_abs  = tgt_ext[28] ? 29'(-tgt_ext) : 29'(tgt_ext);

  // per-request update
  always_comb begin
    state_o = state_i;
    res_o   = '0;
    case (req_i.cmd)
      sdph_pkg::CMD_START: begin
        state_o.target     = req_i.target;
        state_o.speed      = req_i.speed;
        state_o.short_move = req_i.short_move;
        state_o.pos_err    = '0;
        state_o.last_err   = '0;
        state_o.err_sum    = '0;
        state_o.moving     = (req_i.target != '0);
        res_o.done         = (req_i.target == '0);
      end
      sdph_pkg::CMD_SAMPLE: begin
        if (state_i.moving) begin
          res_o.left_power  = sdph_pkg::side_power(pid_q16 + hc_ext);
          res_o.right_power = sdph_pkg::side_power(pid_q16 - hc_ext);
          state_o.last_err  = pos_err;
          state_o.pos_err   = err_new;
          state_o.err_sum   = sum_new;
          if (mean_abs >= tgt_abs) begin
            state_o.moving = 1'b0;
            res_o.done     = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/straight_drive_pid_heading_hold.sv
// Top level of the straight-drive PID controller with heading hold.
// Depends on sdph_pkg, sdph_front and sdph_pid.
//
// Usage:
// - input channel in_valid_i / in_stall_o carries one request: command_i 0
//   starts a move (distance_i, max_speed_i), command_i 1 is a sensor sample
//   (left_ticks_i, right_ticks_i, heading_i)
// - output channel out_valid_o / out_stall_i returns one result per request:
//   left_power_o, right_power_o and done_res_o
// - configuration registers are written through cfg_we_i, cfg_index_i and
//   cfg_wdata_i while no request is in flight
// - a request is held in the front-end register and its result is registered in
//   the result register; throughput is one request per cycle while no result is
//   stalled, set by the move state update, combinational between the registers
// - the front-end register takes a request even while a result is stalled;
//   both stages hold while a valid result stays stalled, and in_stall_o rises once
//   the front-end register is full
// - reset clears the move state (idle, no target), both valid flags and the
//   configuration registers to their defaults
module straight_drive_pid_heading_hold (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic signed [15:0]  distance_i,
  input  logic [6:0]          max_speed_i,
  input  logic signed [27:0]  left_ticks_i,
  input  logic signed [27:0]  right_ticks_i,
  input  logic [15:0]         heading_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [7:0]   left_power_o,
  output logic signed [7:0]   right_power_o,
  output logic                done_res_o
);

  logic [15:0] kp_gain_q;
  logic [15:0] ki_gain_q;
  logic [15:0] kd_gain_q;
  logic [15:0] heading_gain_q;
  logic [15:0] ticks_per_inch_q;
  logic [15:0] target_heading_q;

  sdph_pkg::sdph_req_t   front_req;
  sdph_pkg::sdph_req_t   s1_req_q;
  logic                  s1_valid_q;
  sdph_pkg::sdph_state_t state_q;
  sdph_pkg::sdph_state_t state_d;
  sdph_pkg::sdph_gains_t gains;
  sdph_pkg::sdph_res_t   res_d;
  sdph_pkg::sdph_res_t   res_q;
  logic                  out_valid_q;

  logic                  out_free;
  logic                  s1_adv;
  logic                  in_accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_gain_q        <= sdph_pkg::KP_RESET;
      ki_gain_q        <= '0;
      kd_gain_q        <= '0;
      heading_gain_q   <= '0;
      ticks_per_inch_q <= sdph_pkg::TPI_RESET;
      target_heading_q <= '0;
    end else if (cfg_we_i) begin
      case (sdph_pkg::cfg_idx_e'(cfg_index_i))
        sdph_pkg::CFG_KP_GAIN:        kp_gain_q        <= cfg_wdata_i;
        sdph_pkg::CFG_KI_GAIN:        ki_gain_q        <= cfg_wdata_i;
        sdph_pkg::CFG_KD_GAIN:        kd_gain_q        <= cfg_wdata_i;
        sdph_pkg::CFG_HEADING_GAIN:   heading_gain_q   <= cfg_wdata_i;
        sdph_pkg::CFG_TICKS_PER_INCH: ticks_per_inch_q <= cfg_wdata_i;
        sdph_pkg::CFG_TARGET_HEADING: target_heading_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // handshake between the two stages
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // front-end: target, mean and heading correction
  sdph_front u_front (
    .command_i        (sdph_pkg::cmd_e'(command_i)),
    .distance_i       (distance_i),
    .max_speed_i      (max_speed_i),
    .left_ticks_i     (left_ticks_i),
    .right_ticks_i    (right_ticks_i),
    .heading_i        (heading_i),
    .ticks_per_inch_i (ticks_per_inch_q),
    .target_heading_i (target_heading_q),
    .heading_gain_i   (heading_gain_q),
    .req_o            (front_req)
  );

  // front-end register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q <= front_req;
    end
  end

  // pid datapath
  assign gains.kp = kp_gain_q;
  assign gains.ki = ki_gain_q;
  assign gains.kd = kd_gain_q;

  sdph_pid u_pid (
    .state_i (state_q),
    .gains_i (gains),
    .req_i   (s1_req_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // move state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_power_o  = res_q.left_power;
  assign right_power_o = res_q.right_power;
  assign done_res_o    = res_q.done;

endmodule

FILE: tb/sv/tb_straight_drive_pid_heading_hold.sv
// Self-checking testbench for the straight-drive PID controller with heading hold.
// Holds its own prediction of the drive law and compares every result against it.
// Depends on sdph_pkg and straight_drive_pid_heading_hold.
module tb_straight_drive_pid_heading_hold;
  timeunit 1ns;
  timeprecision 1ps;

  // fixed-point limits of the drive law
  localparam longint POWER_FULL     = 64'sd8323072;       // 127 in 16 fraction bits
  localparam longint INTEGRAL_LIMIT = 64'sd549755813887;  // 2^39 - 1
  localparam longint WRAP_OFFSET    = 64'sd54000;
  localparam longint WRAP_FULL      = 64'sd36000;
  localparam longint WRAP_HALF      = 64'sd18000;
  localparam longint WINDOW_LO      = 64'sd8;
  localparam longint WINDOW_HI      = 64'sd2400;

  typedef enum int {FLOW_OPEN, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  sdph_pkg::cfg_idx_e cfg_index_i = sdph_pkg::CFG_KP_GAIN;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = sdph_pkg::CMD_START;
  logic signed [15:0] distance_i = '0;
  logic [6:0]         max_speed_i = '0;
  logic signed [27:0] left_ticks_i = '0;
  logic signed [27:0] right_ticks_i = '0;
  logic [15:0]        heading_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [7:0]  left_power_o;
  logic signed [7:0]  right_power_o;
  logic               done_res_o;

  // predicted register contents
  logic [15:0] reg_kp = sdph_pkg::KP_RESET;
  logic [15:0] reg_ki = '0;
  logic [15:0] reg_kd = '0;
  logic [15:0] reg_heading_gain = '0;
  logic [15:0] reg_tpi = sdph_pkg::TPI_RESET;
  logic [15:0] reg_target_heading = '0;

  // predicted move state
  longint     move_target = 0;
  longint     move_error = 0;
  longint     prev_error = 0;
  longint     error_integral = 0;
  logic [6:0] move_speed = '0;
  logic       move_short = 1'b0;
  logic       drive_moving = 1'b0;

  sdph_pkg::sdph_res_t expected_powers[$];
  int         mismatches = 0;
  int         requests_sent = 0;
  int         burst_left = 0;
  bit         burst_quiet = 1'b0;
  flow_e      flow_mode = FLOW_OPEN;
  int         flow_left = 0;
  logic [7:0] flow_tick = '0;

  straight_drive_pid_heading_hold uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .distance_i    (distance_i),
    .max_speed_i   (max_speed_i),
    .left_ticks_i  (left_ticks_i),
    .right_ticks_i (right_ticks_i),
    .heading_i     (heading_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_power_o  (left_power_o),
    .right_power_o (right_power_o),
    .done_res_o    (done_res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint limit_to(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic int spread(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // drive law: powers for one request, then the move state update
  task automatic predict_drive_law(input sdph_pkg::cmd_e cmd,
                                   input logic signed [15:0] move_len,
                                   input logic [6:0] spd, input logic signed [27:0] lt,
                                   input logic signed [27:0] rt, input logic [15:0] hdg,
                                   output sdph_pkg::sdph_res_t res);
    longint gain_p, pid, hd, corr, lp, rp, mean;
    res = '0;
    if (cmd == sdph_pkg::CMD_START) begin
      move_target    = (longint'(move_len) * longint'(reg_tpi)) / 256;
      move_speed     = spd;
      move_short     = (move_len < 16'sd192);
      move_error     = 0;
      prev_error     = 0;
      error_integral = 0;
      drive_moving   = (move_target != 0);
      res.done       = !drive_moving;
    end else if (drive_moving) begin
      gain_p = longint'(reg_kp) * (move_short ? 2 : 1);
      pid = move_error * gain_p + error_integral * longint'(reg_ki)
          + (move_error - prev_error) * longint'(reg_kd);
      pid = limit_to(pid, longint'(move_speed) * 256);
      // wrapped heading error in -18000..17999
      hd = longint'(reg_target_heading) - longint'(hdg) + WRAP_OFFSET;
      hd = hd % WRAP_FULL;
      if (hd < 0) hd += WRAP_FULL;
      corr = (hd - WRAP_HALF) * longint'(reg_heading_gain);
      lp = limit_to(pid * 256 + corr, POWER_FULL) / 65536;
      rp = limit_to(pid * 256 - corr, POWER_FULL) / 65536;
      res.left_power  = lp[7:0];
      res.right_power = rp[7:0];
      // floor of the mean side position
      mean = (longint'(lt) + longint'(rt)) >>> 1;
      prev_error = move_error;
      move_error = move_target - mean;
      if (magnitude(move_error) < WINDOW_LO || magnitude(move_error) > WINDOW_HI) begin
        error_integral = 0;
      end else begin
        error_integral = limit_to(error_integral + move_error, INTEGRAL_LIMIT);
      end
      if (magnitude(mean) >= magnitude(move_target)) begin
        drive_moving = 1'b0;
        res.done     = 1'b1;
      end
    end
  endtask

  // sender pacing: bursts with gaps, some bursts without any gap
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = burst_quiet ? 0 : $urandom_range(1, 7);
      burst_quiet = ($urandom_range(0, 4) == 0);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // present one request and hold it until it is taken
  task automatic send_request(input sdph_pkg::cmd_e cmd, input logic signed [15:0] move_len,
                              input logic [6:0] spd, input logic signed [27:0] lt,
                              input logic signed [27:0] rt, input logic [15:0] hdg);
    sdph_pkg::sdph_res_t want;
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    distance_i    <= move_len;
    max_speed_i   <= spd;
    left_ticks_i  <= lt;
    right_ticks_i <= rt;
    heading_i     <= hdg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_drive_law(cmd, move_len, spd, lt, rt, hdg, want);
    expected_powers.push_back(want);
    requests_sent++;
    pace_sender();
  endtask

  // unused fields carry random bits
  task automatic send_start(input logic signed [15:0] move_len, input logic [6:0] spd);
    send_request(sdph_pkg::CMD_START, move_len, spd, 28'($urandom), 28'($urandom),
                 16'($urandom));
  endtask

  task automatic send_sample(input logic signed [27:0] lt, input logic signed [27:0] rt,
                             input logic [15:0] hdg);
    send_request(sdph_pkg::CMD_SAMPLE, 16'($urandom), 7'($urandom), lt, rt, hdg);
  endtask

  // wait until every result is back and the pipeline is quiet
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input sdph_pkg::cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sdph_pkg::CFG_KP_GAIN:        reg_kp = value;
      sdph_pkg::CFG_KI_GAIN:        reg_ki = value;
      sdph_pkg::CFG_KD_GAIN:        reg_kd = value;
      sdph_pkg::CFG_HEADING_GAIN:   reg_heading_gain = value;
      sdph_pkg::CFG_TICKS_PER_INCH: reg_tpi = value;
      sdph_pkg::CFG_TARGET_HEADING: reg_target_heading = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // idle samples, zero-length move and a short move at reset settings
  task automatic test_idle_and_zero_move();
    send_sample(28'($urandom), 28'($urandom), 16'($urandom));
    send_start(16'sd0, 7'd127);
    send_sample(28'($urandom), 28'($urandom), 16'($urandom));
    send_start(16'sd16, 7'd127);
    send_sample(28'sd0, 28'sd0, 16'd0);
    send_sample(28'sd301, 28'sd298, 16'd9000);
    // odd negative sum rounds down
    send_sample(-28'sd3, 28'sd0, 16'd18000);
    send_sample(28'sd620, 28'sd621, 16'd27000);
  endtask

  // full-scale gains and fields, restart during a move, short-move boundary
  task automatic test_field_extremes();
    drain_requests();
    write_reg(sdph_pkg::CFG_KP_GAIN, 16'hFFFF);
    write_reg(sdph_pkg::CFG_KI_GAIN, 16'hFFFF);
    write_reg(sdph_pkg::CFG_KD_GAIN, 16'hFFFF);
    write_reg(sdph_pkg::CFG_HEADING_GAIN, 16'hFFFF);
    write_reg(sdph_pkg::CFG_TICKS_PER_INCH, 16'hFFFF);
    write_reg(sdph_pkg::CFG_TARGET_HEADING, 16'd35999);
    send_start(16'sd32767, 7'd127);
    send_sample(28'sh7FFFFFF, 28'sh8000000, 16'd0);
    send_sample(28'sh8000000, 28'sh8000000, 16'hFFFF);
    send_start(-16'sd32768, 7'd0);
    send_sample(28'sd0, 28'sd0, 16'd35999);
    send_start(16'sd192, 7'd1);
    send_sample(28'sd0, 28'sd0, 16'd17999);
    send_start(16'sd191, 7'd127);
    send_sample(28'sd48000, 28'sd48000, 16'd0);
    send_sample(28'sd48890, 28'sd48890, 16'd0);
    send_sample(28'sd60000, 28'sd60001, 16'd0);
  endtask

  // heading reference outside one turn, and a zero scale that ends every move at once
  task automatic test_heading_wrap_and_zero_scale();
    drain_requests();
    write_reg(sdph_pkg::CFG_TARGET_HEADING, 16'hFFFF);
    send_start(-16'sd5, 7'd100);
    send_sample(28'sd0, 28'sd0, 16'd100);
    send_sample(-28'sd1279, -28'sd1280, 16'd0);
    drain_requests();
    write_reg(sdph_pkg::CFG_TICKS_PER_INCH, 16'd0);
    send_start(16'sd100, 7'd50);
    send_sample(28'($urandom), 28'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 31));
      1:       return 16'($urandom_range(0, 1023));
      2:       return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_heading();
    if ($urandom_range(0, 9) < 7) begin
      return 16'((int'(reg_target_heading) + spread(3000) + 72000) % 36000);
    end
    return 16'($urandom);
  endfunction

  task automatic configure_random();
    drain_requests();
    write_reg(sdph_pkg::CFG_KP_GAIN, pick_gain());
    write_reg(sdph_pkg::CFG_KI_GAIN, pick_gain());
    write_reg(sdph_pkg::CFG_KD_GAIN, pick_gain());
    write_reg(sdph_pkg::CFG_HEADING_GAIN, ($urandom_range(0, 2) == 0) ? pick_gain()
                                          : 16'($urandom_range(0, 3000)));
    case ($urandom_range(0, 7))
      0:       write_reg(sdph_pkg::CFG_TICKS_PER_INCH, 16'hFFFF);
      1:       write_reg(sdph_pkg::CFG_TICKS_PER_INCH, 16'd1);
      default: write_reg(sdph_pkg::CFG_TICKS_PER_INCH, 16'($urandom_range(1, 65535)));
    endcase
    case ($urandom_range(0, 7))
      0:       write_reg(sdph_pkg::CFG_TARGET_HEADING, 16'd35999);
      1:       write_reg(sdph_pkg::CFG_TARGET_HEADING, 16'($urandom));
      default: write_reg(sdph_pkg::CFG_TARGET_HEADING, 16'($urandom_range(0, 35999)));
    endcase
  endtask

  // one move: start, then samples closing on the target
  task automatic run_drive_move();
    logic signed [15:0] move_len;
    longint goal, dir, mean;
    int steps, pick, d;
    pick = $urandom_range(0, 19);
    if (pick < 12) move_len = 16'(int'($urandom_range(0, 1600)) - 400);
    else if (pick < 17) move_len = 16'($urandom);
    else move_len = 16'(spread(20));
    send_start(move_len, 7'($urandom));
    goal  = move_target;
    dir   = (goal < 0) ? -1 : 1;
    steps = $urandom_range(2, 14);
    for (int k = 1; k <= steps && drive_moving; k++) begin
      pick = $urandom_range(0, 19);
      // abandoned move: the next start restarts it
      if (pick == 0) return;
      if (pick < 3 && k != steps) begin
        send_sample(28'($urandom), 28'($urandom), pick_heading());
      end else begin
        if (k == steps) mean = goal + dir * longint'($urandom_range(0, 50));
        else if (k == steps - 1) mean = goal - dir * longint'($urandom_range(0, 3000));
        else mean = (goal * k) / steps + spread(40);
        d = spread(2000);
        send_sample(28'(mean + d), 28'(mean - d + $urandom_range(0, 1)), pick_heading());
      end
    end
  endtask

  // random phases, each with its own settings
  task automatic test_random_moves();
    int phase_start;
    for (int phase = 0; phase < 8; phase++) begin
      configure_random();
      phase_start = requests_sent;
      while (requests_sent - phase_start < 88) begin
        case ($urandom_range(0, 11))
          0:       send_sample(28'($urandom), 28'($urandom), 16'($urandom));
          1:       send_start(16'($urandom), 7'($urandom));
          2:       drain_requests();
          default: run_drive_move();
        endcase
      end
    end
  endtask

  // receiver stall pattern, switching mode now and then
  always @(posedge clk_i) begin
    if (flow_left == 0) begin
      flow_mode <= flow_e'($urandom_range(0, 3));
      flow_left <= $urandom_range(10, 150);
    end else begin
      flow_left <= flow_left - 1;
    end
    flow_tick <= flow_tick + 8'd1;
    case (flow_mode)
      FLOW_OPEN:  out_stall_i <= 1'b0;
      FLOW_LIGHT: out_stall_i <= ($urandom_range(0, 4) == 0);
      FLOW_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= (flow_tick[2:0] == 3'd5) || (flow_tick[2:0] == 3'd6);
    endcase
  end

  // compare each delivered result with the oldest prediction
  always @(posedge clk_i) begin : check_powers
    sdph_pkg::sdph_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected result left %0d right %0d done %0b", $time,
                 left_power_o, right_power_o, done_res_o);
        mismatches++;
      end else begin
        want = expected_powers.pop_front();
        if (left_power_o !== want.left_power) begin
          $display("%0t: left_power expected %0d got %0d", $time,
                   want.left_power, left_power_o);
          mismatches++;
        end
        if (right_power_o !== want.right_power) begin
          $display("%0t: right_power expected %0d got %0d", $time,
                   want.right_power, right_power_o);
          mismatches++;
        end
        if (done_res_o !== want.done) begin
          $display("%0t: done_res expected %0b got %0b", $time, want.done, done_res_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_and_zero_move();
    test_field_extremes();
    test_heading_wrap_and_zero_scale();
    test_random_moves();
    drain_requests();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_powers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
